@@ design/v3alu_pkg.sv @@
package v3alu_pkg;

  // Operation codes carried in the opcode field.
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DOT   = 3'd3,
    OP_CROSS = 3'd4,
    OP_MAG   = 3'd5,
    OP_NORM  = 3'd6,
    OP_DIST  = 3'd7
  } v3alu_op_t;

  localparam int OPCODE_WIDTH = 3;

endpackage

@@ design/v3alu_if.sv @@
// Command channel: opcode, two vectors and a scale factor.
interface v3alu_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   opcode;
  logic signed [DATA_WIDTH-1:0] ax;
  logic signed [DATA_WIDTH-1:0] ay;
  logic signed [DATA_WIDTH-1:0] az;
  logic signed [DATA_WIDTH-1:0] bx;
  logic signed [DATA_WIDTH-1:0] by_comp;
  logic signed [DATA_WIDTH-1:0] bz;
  logic signed [DATA_WIDTH-1:0] factor;

  modport source (output valid, opcode, ax, ay, az, bx, by_comp, bz, factor, input ready);
  modport sink (input valid, opcode, ax, ay, az, bx, by_comp, bz, factor, output ready);
endinterface

// Result channel: vector, scalar and flags.
interface v3alu_out_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] rx;
  logic signed [DATA_WIDTH-1:0] ry;
  logic signed [DATA_WIDTH-1:0] rz;
  logic signed [DATA_WIDTH-1:0] scalar_out;
  logic                         zero_length;
  logic                         saturated;

  modport source (output valid, rx, ry, rz, scalar_out, zero_length, saturated, input ready);
  modport sink (input valid, rx, ry, rz, scalar_out, zero_length, saturated, output ready);
endinterface

@@ design/vector3_alu.sv @@
// 3D vector ALU in signed fixed point (DATA_WIDTH-bit words, FRAC_BITS fraction
// bits; Q16.16 by default). Operations: add, subtract, scale, dot, cross,
// magnitude, normalize and distance; each command transaction gives exactly one
// result transaction. The unit is a single in-order pipeline that accepts one
// transaction per clock while not stalled. Every operation passes the same
// stages: four front stages (operands, multipliers, sums, saturation),
// DATA_WIDTH+1 square-root stages at one root bit each, DATA_WIDTH+FRAC_BITS
// divider stages at one quotient bit each, and the output register. When the
// result is not taken the whole pipeline holds, so command ready is low
// exactly while a result waits and the sink is not ready. Clamped results
// raise saturated; normalize of a zero vector returns zeros with zero_length
// set.
module vector3_alu #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic          clk,
  input logic          rst,
  v3alu_in_if.sink     cmd,
  v3alu_out_if.source  res
);
  import v3alu_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int SW = 2 * W + 2;
  localparam int RW = W + 1;
  localparam int NW = W + F;
  localparam logic signed [NW:0] NMAX = {{(NW-W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [NW:0] NMIN = ~NMAX;
  localparam logic [RW-1:0] RMAX = {2'b00, {(W-1){1'b1}}};

  typedef struct packed {
    v3alu_op_t        op;
    logic [2:0][W-1:0] vec;
    logic [W-1:0]     scal;
    logic             sat;
    logic [2:0]       aneg;
  } res_side_t;

  typedef struct packed {
    res_side_t        r;
    logic [2:0][W-1:0] amag;
  } sqrt_side_t;

  typedef struct packed {
    res_side_t        r;
    logic [RW-1:0]    root;
  } div_side_t;

  logic               en;
  logic               fv;
  v3alu_op_t          fop;
  logic [2:0][W-1:0]  fvec;
  logic [W-1:0]       fscal;
  logic               fsat;
  logic [SW-1:0]      fsq;
  logic [2:0][W-1:0]  famag;
  logic [2:0]         faneg;
  sqrt_side_t         sq_side;
  sqrt_side_t         sq_side_o;
  logic               sq_v;
  logic [RW-1:0]      root;
  logic [2:0][NW-1:0] dnum;
  div_side_t          dv_side;
  div_side_t          dv_side_o;
  logic               dv_v;
  logic [2:0][NW-1:0] quo;

  logic               out_valid;
  logic [2:0][W-1:0]  out_vec;
  logic [W-1:0]       out_scal;
  logic               out_zl;
  logic               out_sat;
  logic [2:0][W-1:0]  vec_next;
  logic [W-1:0]       scal_next;
  logic               zl_next;
  logic               sat_next;
  logic signed [NW:0] nq;

  // The whole pipeline advances unless a finished result is being held.
  assign en = !out_valid || res.ready;
  assign cmd.ready = en;

  v3alu_front #(.W(W), .F(F)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cmd.valid),
    .opcode    (cmd.opcode),
    .av        ({cmd.az, cmd.ay, cmd.ax}),
    .bv        ({cmd.bz, cmd.by_comp, cmd.bx}),
    .factor    (cmd.factor),
    .out_valid (fv),
    .op_o      (fop),
    .vec       (fvec),
    .scal      (fscal),
    .sat       (fsat),
    .sq        (fsq),
    .amag      (famag),
    .aneg      (faneg)
  );

  assign sq_side.r.op   = fop;
  assign sq_side.r.vec  = fvec;
  assign sq_side.r.scal = fscal;
  assign sq_side.r.sat  = fsat;
  assign sq_side.r.aneg = faneg;
  assign sq_side.amag   = famag;

  v3alu_sqrt #(.SW(SW), .RW(RW), .SDW($bits(sqrt_side_t))) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fv),
    .s         (fsq),
    .side      (sq_side),
    .out_valid (sq_v),
    .root      (root),
    .side_o    (sq_side_o)
  );

  // Normalize numerators are the component magnitudes with fraction bits added.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dnum[j] = {sq_side_o.amag[j], {F{1'b0}}};
    end
  end
  assign dv_side.r    = sq_side_o.r;
  assign dv_side.root = root;

  v3alu_div #(.NW(NW), .DW(RW), .SDW($bits(div_side_t))) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v),
    .num       (dnum),
    .d         (root),
    .side      (dv_side),
    .out_valid (dv_v),
    .quo       (quo),
    .side_o    (dv_side_o)
  );

  // Final result selection and clamping of root and quotients.
  always_comb begin
    vec_next  = dv_side_o.r.vec;
    scal_next = dv_side_o.r.scal;
    sat_next  = dv_side_o.r.sat;
    zl_next   = 1'b0;
    nq        = '0;
    case (dv_side_o.r.op)
      OP_MAG, OP_DIST: begin
        vec_next = '0;
        if (dv_side_o.root > RMAX) begin
          scal_next = RMAX[W-1:0];
          sat_next  = 1'b1;
        end else begin
          scal_next = dv_side_o.root[W-1:0];
          sat_next  = 1'b0;
        end
      end
      OP_NORM: begin
        scal_next = '0;
        sat_next  = 1'b0;
        if (dv_side_o.root == '0) begin
          vec_next = '0;
          zl_next  = 1'b1;
        end else begin
          for (int j = 0; j < 3; j++) begin
            nq = dv_side_o.r.aneg[j] ? -$signed({1'b0, quo[j]}) : $signed({1'b0, quo[j]});
            if (nq > NMAX) begin
              vec_next[j] = NMAX[W-1:0];
              sat_next    = 1'b1;
            end else if (nq < NMIN) begin
              vec_next[j] = NMIN[W-1:0];
              sat_next    = 1'b1;
            end else begin
              vec_next[j] = nq[W-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec  <= vec_next;
      out_scal <= scal_next;
      out_zl   <= zl_next;
      out_sat  <= sat_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.rx          = out_vec[0];
  assign res.ry          = out_vec[1];
  assign res.rz          = out_vec[2];
  assign res.scalar_out  = out_scal;
  assign res.zero_length = out_zl;
  assign res.saturated   = out_sat;

`ifndef ASSERT_OFF
  // A zero-length normalize gives an all-zero result.
  a_zl_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_zl |-> out_vec == '0 && out_scal == '0)
    else $error("zero_length with nonzero result");

  // Scalar operations never produce a vector.
  a_scalar_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_scal != '0 |-> out_vec == '0)
    else $error("scalar and vector result both nonzero");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !fv && !sq_v && !dv_v)
    else $error("pipeline valid after reset");
`endif

endmodule

@@ design/v3alu_front.sv @@
// Front end: operand select, products, sums and saturation in four stages.
module v3alu_front #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [2:0]             opcode,
  input  logic [2:0][W-1:0]      av,
  input  logic [2:0][W-1:0]      bv,
  input  logic [W-1:0]           factor,
  output logic                   out_valid,
  output v3alu_pkg::v3alu_op_t   op_o,
  output logic [2:0][W-1:0]      vec,
  output logic [W-1:0]           scal,
  output logic                   sat,
  output logic [2*W+1:0]         sq,
  output logic [2:0][W-1:0]      amag,
  output logic [2:0]             aneg
);
  import v3alu_pkg::*;

  localparam int VW = W + 1;
  localparam int PW = 2 * VW;
  localparam int CW = PW + 2;
  localparam int SW = 2 * W + 2;
  localparam logic signed [CW-1:0] MAXV = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = ~MAXV;

  // Clamp to the word range; the top bit is the clamp flag.
  function automatic logic [W:0] sat_fn(input logic signed [CW-1:0] x);
    logic [W:0] r;
    if (x > MAXV) begin
      r = {1'b1, MAXV[W-1:0]};
    end else if (x < MINV) begin
      r = {1'b1, MINV[W-1:0]};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  // Stage 1 registers.
  logic                   v1;
  v3alu_op_t              op1;
  logic signed [VW-1:0]   a1 [3];
  logic signed [VW-1:0]   b1 [3];
  logic signed [VW-1:0]   f1;

  // Stage 2 registers.
  logic                   v2;
  v3alu_op_t              op2;
  logic signed [PW-1:0]   p2 [6];
  logic signed [VW-1:0]   as2 [3];
  logic signed [VW-1:0]   a2 [3];

  // Stage 3 registers.
  logic                   v3;
  v3alu_op_t              op3;
  logic signed [CW-1:0]   r3 [3];
  logic signed [CW-1:0]   s3;
  logic [SW-1:0]          sq3;
  logic signed [VW-1:0]   a3 [3];

  logic signed [VW-1:0]   xm [6];
  logic signed [VW-1:0]   ym [6];
  logic signed [CW-1:0]   pe [6];
  logic signed [CW-1:0]   sum3;
  logic signed [CW-1:0]   r3_next [3];
  logic signed [CW-1:0]   s3_next;
  logic [W:0]             sv [3];
  logic [W:0]             ss;
  logic signed [VW-1:0]   aabs [3];

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // Stage 1: register operands; distance works on A minus B.
  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= v3alu_op_t'(opcode);
      for (int i = 0; i < 3; i++) begin
        if (v3alu_op_t'(opcode) == OP_DIST) begin
          a1[i] <= $signed({av[i][W-1], av[i]}) - $signed({bv[i][W-1], bv[i]});
        end else begin
          a1[i] <= $signed({av[i][W-1], av[i]});
        end
        b1[i] <= $signed({bv[i][W-1], bv[i]});
      end
      f1 <= $signed({factor[W-1], factor});
    end
  end

  // Multiplier operand selection per operation.
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      xm[j] = '0;
      ym[j] = '0;
    end
    case (op1)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          xm[i] = a1[i];
          ym[i] = f1;
        end
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          xm[i] = a1[i];
          ym[i] = b1[i];
        end
      end
      OP_CROSS: begin
        xm[0] = a1[1]; ym[0] = b1[2];
        xm[1] = a1[2]; ym[1] = b1[1];
        xm[2] = a1[2]; ym[2] = b1[0];
        xm[3] = a1[0]; ym[3] = b1[2];
        xm[4] = a1[0]; ym[4] = b1[1];
        xm[5] = a1[1]; ym[5] = b1[0];
      end
      OP_MAG, OP_NORM, OP_DIST: begin
        for (int i = 0; i < 3; i++) begin
          xm[i] = a1[i];
          ym[i] = a1[i];
        end
      end
      default: begin
      end
    endcase
  end

  // Stage 2: products, and the sums for add and subtract.
  always_ff @(posedge clk) begin
    if (en) begin
      op2 <= op1;
      for (int j = 0; j < 6; j++) begin
        p2[j] <= xm[j] * ym[j];
      end
      for (int i = 0; i < 3; i++) begin
        as2[i] <= (op1 == OP_SUB) ? a1[i] - b1[i] : a1[i] + b1[i];
        a2[i] <= a1[i];
      end
    end
  end

  // Combine products and drop the extra fraction bits.
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      pe[j] = {{(CW-PW){p2[j][PW-1]}}, p2[j]};
    end
    sum3 = pe[0] + pe[1] + pe[2];
    for (int i = 0; i < 3; i++) begin
      r3_next[i] = '0;
    end
    s3_next = '0;
    case (op2)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          r3_next[i] = {{(CW-VW){as2[i][VW-1]}}, as2[i]};
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          r3_next[i] = pe[i] >>> F;
        end
      end
      OP_DOT: s3_next = sum3 >>> F;
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          r3_next[i] = (pe[2*i] - pe[2*i+1]) >>> F;
        end
      end
      default: begin
      end
    endcase
  end

  // Stage 3 registers.
  always_ff @(posedge clk) begin
    if (en) begin
      op3 <= op2;
      s3  <= s3_next;
      sq3 <= sum3[SW-1:0];
      for (int i = 0; i < 3; i++) begin
        r3[i] <= r3_next[i];
        a3[i] <= a2[i];
      end
    end
  end

  // Saturate, and prepare magnitudes for normalize.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i] = sat_fn(r3[i]);
      aabs[i] = a3[i][VW-1] ? -a3[i] : a3[i];
    end
    ss = sat_fn(s3);
  end

  // Stage 4 registers.
  always_ff @(posedge clk) begin
    if (en) begin
      op_o <= op3;
      scal <= ss[W-1:0];
      sat  <= sv[0][W] | sv[1][W] | sv[2][W] | ss[W];
      sq   <= sq3;
      for (int i = 0; i < 3; i++) begin
        vec[i]  <= sv[i][W-1:0];
        amag[i] <= aabs[i][W-1:0];
        aneg[i] <= a3[i][VW-1];
      end
    end
  end

endmodule

@@ design/v3alu_sqrt.sv @@
// Integer square root, one result bit per pipeline stage.
module v3alu_sqrt #(
  parameter int SW  = 66,
  parameter int RW  = 33,
  parameter int SDW = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [SW-1:0]  s,
  input  logic [SDW-1:0] side,
  output logic           out_valid,
  output logic [RW-1:0]  root,
  output logic [SDW-1:0] side_o
);
  import v3alu_pkg::*;

  logic           vld   [RW];
  logic [SW-1:0]  rem_q [RW];
  logic [RW-1:0]  res_q [RW];
  logic [SDW-1:0] sd_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic           v_in;
    logic [SW-1:0]  rem_in;
    logic [RW-1:0]  res_in;
    logic [SDW-1:0] sd_in;
    logic [SW:0]    trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = s;
      assign res_in = '0;
      assign sd_in  = side;
    end else begin : g_next
      assign v_in   = vld[k-1];
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
      assign sd_in  = sd_q[k-1];
    end

    // Adding this bit raises the square by 2*res*2^B + 2^(2B).
    assign trial = ({{(SW+1-RW){1'b0}}, res_in} << (B + 1)) | ((SW+1)'(1) << (2 * B));
    assign ge    = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? rem_in - trial[SW-1:0] : rem_in;
        res_q[k] <= ge ? (res_in | (RW'(1) << B)) : res_in;
        sd_q[k]  <= sd_in;
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = res_q[RW-1];
  assign side_o    = sd_q[RW-1];

endmodule

@@ design/v3alu_div.sv @@
// Three restoring dividers sharing one divisor, one quotient bit per stage.
module v3alu_div #(
  parameter int NW  = 48,
  parameter int DW  = 33,
  parameter int SDW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2:0][NW-1:0] num,
  input  logic [DW-1:0]      d,
  input  logic [SDW-1:0]     side,
  output logic               out_valid,
  output logic [2:0][NW-1:0] quo,
  output logic [SDW-1:0]     side_o
);
  import v3alu_pkg::*;

  logic               vld   [NW];
  logic [2:0][NW-1:0] num_q [NW];
  logic [2:0][NW-1:0] q_q   [NW];
  logic [2:0][DW-1:0] rem_q [NW];
  logic [DW-1:0]      d_q   [NW];
  logic [SDW-1:0]     sd_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    localparam int I = NW - 1 - k;
    logic               v_in;
    logic [2:0][NW-1:0] num_in;
    logic [2:0][NW-1:0] q_in;
    logic [2:0][DW-1:0] rem_in;
    logic [DW-1:0]      d_in;
    logic [SDW-1:0]     sd_in;
    logic [2:0][DW:0]   rem2;
    logic [2:0]         ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign num_in = num;
      assign q_in   = '0;
      assign rem_in = '0;
      assign d_in   = d;
      assign sd_in  = side;
    end else begin : g_next
      assign v_in   = vld[k-1];
      assign num_in = num_q[k-1];
      assign q_in   = q_q[k-1];
      assign rem_in = rem_q[k-1];
      assign d_in   = d_q[k-1];
      assign sd_in  = sd_q[k-1];
    end

    // Bring down the next numerator bit and try the subtract.
    always_comb begin
      for (int j = 0; j < 3; j++) begin
        rem2[j] = {rem_in[j], num_in[j][I]};
        ge[j]   = rem2[j] >= {1'b0, d_in};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_q[k] <= num_in;
        d_q[k]   <= d_in;
        sd_q[k]  <= sd_in;
        for (int j = 0; j < 3; j++) begin
          rem_q[k][j] <= ge[j] ? DW'(rem2[j] - {1'b0, d_in}) : rem2[j][DW-1:0];
          q_q[k][j]   <= {q_in[j][NW-2:0], ge[j]};
        end
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = q_q[NW-1];
  assign side_o    = sd_q[NW-1];

endmodule

@@ sim/tb.sv @@
module tb;
  import v3alu_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int N_RANDOM = 2000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    v3alu_op_t          op;
    logic signed [DW-1:0] ax, ay, az, bx, by_comp, bz, factor;
  } vec_cmd_t;

  typedef struct {
    logic signed [DW-1:0] rx, ry, rz, scalar_out;
    logic                 zero_length, saturated;
  } vec_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  v3alu_in_if  #(.DATA_WIDTH(DW)) cmd_if ();
  v3alu_out_if #(.DATA_WIDTH(DW)) res_if ();

  vector3_alu #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  vec_cmd_t pending_cmds[$];
  vec_res_t expected_results[$];
  int       accepted_cmds = 0;
  int       mismatches = 0;
  int       hold_cycles = 0;
  bit       hold_done = 1'b0;

  always #5 clk = ~clk;

  // Clamp a wide signed value to the word range, raising the flag when clamped.
  function automatic logic signed [DW-1:0] clamp_word(input logic signed [127:0] x,
                                                      inout logic flag);
    logic signed [127:0] maxv, minv;
    maxv = (128'sd1 <<< (DW - 1)) - 1;
    minv = -(128'sd1 <<< (DW - 1));
    if (x > maxv) begin
      flag = 1'b1;
      return maxv[DW-1:0];
    end
    if (x < minv) begin
      flag = 1'b1;
      return minv[DW-1:0];
    end
    return x[DW-1:0];
  endfunction

  // Floor of the square root, one root bit at a time.
  function automatic logic [35:0] floor_sqrt(input logic [127:0] s);
    logic [35:0]  root, trial;
    logic [127:0] sq;
    root = '0;
    for (int b = 35; b >= 0; b--) begin
      trial = root | (36'd1 << b);
      sq = 128'(trial) * 128'(trial);
      if (sq <= s) root = trial;
    end
    return root;
  endfunction

  // Expected result of one command, computed at full precision.
  function automatic vec_res_t vector_result(input vec_cmd_t c);
    vec_res_t            r;
    logic signed [127:0] a[3], b[3], d[3], t, num, q, sumsq;
    logic [35:0]         m;
    logic                sat;
    int                  j, k;
    a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
    b[0] = c.bx; b[1] = c.by_comp; b[2] = c.bz;
    r = '{default: '0};
    sat = 1'b0;
    case (c.op)
      OP_ADD: begin
        r.rx = clamp_word(a[0] + b[0], sat);
        r.ry = clamp_word(a[1] + b[1], sat);
        r.rz = clamp_word(a[2] + b[2], sat);
      end
      OP_SUB: begin
        r.rx = clamp_word(a[0] - b[0], sat);
        r.ry = clamp_word(a[1] - b[1], sat);
        r.rz = clamp_word(a[2] - b[2], sat);
      end
      OP_SCALE: begin
        t = c.factor;
        r.rx = clamp_word((a[0] * t) >>> FB, sat);
        r.ry = clamp_word((a[1] * t) >>> FB, sat);
        r.rz = clamp_word((a[2] * t) >>> FB, sat);
      end
      OP_DOT: begin
        t = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        r.scalar_out = clamp_word(t >>> FB, sat);
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          t = (a[j] * b[k] - a[k] * b[j]) >>> FB;
          case (i)
            0: r.rx = clamp_word(t, sat);
            1: r.ry = clamp_word(t, sat);
            default: r.rz = clamp_word(t, sat);
          endcase
        end
      end
      OP_MAG: begin
        sumsq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        r.scalar_out = clamp_word(128'(floor_sqrt(sumsq)), sat);
      end
      OP_NORM: begin
        sumsq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        m = floor_sqrt(sumsq);
        if (m == 0) begin
          r.zero_length = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            num = (a[i] < 0) ? -a[i] : a[i];
            q = (num <<< FB) / 128'(m);
            if (a[i] < 0) q = -q;
            case (i)
              0: r.rx = clamp_word(q, sat);
              1: r.ry = clamp_word(q, sat);
              default: r.rz = clamp_word(q, sat);
            endcase
          end
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) d[i] = a[i] - b[i];
        sumsq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        r.scalar_out = clamp_word(128'(floor_sqrt(sumsq)), sat);
      end
    endcase
    r.saturated = sat;
    return r;
  endfunction

  // Operand values: full range most often, with small values, unit-ish and extremes.
  function automatic logic signed [DW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3, 4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      5: return $signed($urandom_range(0, 32'h7ff)) - 32'sh400;
      6: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom_range(0, 1) ? 32'sh00010000 : -32'sh00010000;
    endcase
  endfunction

  function automatic vec_cmd_t make_cmd(input v3alu_op_t op,
                                        input logic signed [DW-1:0] v);
    vec_cmd_t c;
    c.op = op;
    c.ax = v; c.ay = v; c.az = v;
    c.bx = -v; c.by_comp = v; c.bz = ~v;
    c.factor = v;
    return c;
  endfunction

  // Sender idle rate by phase of the run.
  function automatic int send_idle_pct();
    if (accepted_cmds < 700) return 14;
    if (accepted_cmds < 1400) return 76;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted_cmds < 700) return 76;
    if (accepted_cmds < 1400) return 14;
    return 0;
  endfunction

  // Driver: records each accepted transaction and offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        expected_results.push_back(vector_result('{op: v3alu_op_t'(cmd_if.opcode),
          ax: cmd_if.ax, ay: cmd_if.ay, az: cmd_if.az, bx: cmd_if.bx,
          by_comp: cmd_if.by_comp, bz: cmd_if.bz, factor: cmd_if.factor}));
        accepted_cmds++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          vec_cmd_t c;
          c = pending_cmds.pop_front();
          cmd_if.valid   <= 1'b1;
          cmd_if.opcode  <= c.op;
          cmd_if.ax      <= c.ax;
          cmd_if.ay      <= c.ay;
          cmd_if.az      <= c.az;
          cmd_if.bx      <= c.bx;
          cmd_if.by_comp <= c.by_comp;
          cmd_if.bz      <= c.bz;
          cmd_if.factor  <= c.factor;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, mid-run, so the pipeline fills and stalls.
  always @(posedge clk) begin
    if (!rst && !hold_done && accepted_cmds >= 1500) begin
      if (hold_cycles < 300) hold_cycles <= hold_cycles + 1;
      else hold_done <= 1'b1;
    end
  end

  // Result sink ready.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (!hold_done && accepted_cmds >= 1500) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction at %0t", $time);
      end else begin
        vec_res_t e;
        e = expected_results.pop_front();
        if (res_if.rx !== e.rx || res_if.ry !== e.ry || res_if.rz !== e.rz ||
            res_if.scalar_out !== e.scalar_out || res_if.zero_length !== e.zero_length ||
            res_if.saturated !== e.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: exp %h %h %h %h zl=%b sat=%b, got %h %h %h %h zl=%b sat=%b",
                     $time, e.rx, e.ry, e.rz, e.scalar_out, e.zero_length, e.saturated,
                     res_if.rx, res_if.ry, res_if.rz, res_if.scalar_out,
                     res_if.zero_length, res_if.saturated);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    vec_cmd_t c;
    cmd_if.valid = 1'b0;
    cmd_if.opcode = '0;
    cmd_if.ax = '0; cmd_if.ay = '0; cmd_if.az = '0;
    cmd_if.bx = '0; cmd_if.by_comp = '0; cmd_if.bz = '0;
    cmd_if.factor = '0;
    res_if.ready = 1'b0;

    // Directed: every operation at the extremes, zero vectors and unit values.
    for (int op = 0; op < 8; op++) begin
      pending_cmds.push_back(make_cmd(v3alu_op_t'(op), 32'sh7fffffff));
      pending_cmds.push_back(make_cmd(v3alu_op_t'(op), 32'sh80000000));
    end
    pending_cmds.push_back(make_cmd(OP_NORM, 32'sd0));
    pending_cmds.push_back(make_cmd(OP_NORM, 32'sd1));
    pending_cmds.push_back(make_cmd(OP_MAG, 32'sd0));
    pending_cmds.push_back(make_cmd(OP_SCALE, 32'sh00010000));
    pending_cmds.push_back(make_cmd(OP_DOT, -32'sh00010000));
    pending_cmds.push_back(make_cmd(OP_DIST, 32'sd0));

    // Random commands.
    for (int n = 0; n < N_RANDOM; n++) begin
      c.op = v3alu_op_t'($urandom_range(0, 7));
      c.ax = rand_word(); c.ay = rand_word(); c.az = rand_word();
      c.bx = rand_word(); c.by_comp = rand_word(); c.bz = rand_word();
      c.factor = rand_word();
      if (c.op == OP_NORM && $urandom_range(0, 19) == 0) begin
        c.ax = '0; c.ay = '0; c.az = '0;
      end
      pending_cmds.push_back(c);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || cmd_if.valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/v3alu_pkg.sv
design/v3alu_if.sv
design/v3alu_front.sv
design/v3alu_sqrt.sv
design/v3alu_div.sv
design/vector3_alu.sv
sim/tb.sv
